// ===== hdl/rmod_pkg.sv =====
// Shared types, constants and sine table generator for the ring modulator.
package rmod_pkg;

    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned SINE_W     = 16;
    localparam int unsigned NUM_FIELDS = 4;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned ACTIVE_W   = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 4'd1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 3'd2;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SINE_W-1:0]   t_sine;

    // One Taylor term step: divide by (2n)(2n+1)
    function automatic longint unsigned term_div(int unsigned n, longint unsigned v);
        case (n)
            1:       return v / 6;
            2:       return v / 20;
            3:       return v / 42;
            4:       return v / 72;
            5:       return v / 110;
            6:       return v / 156;
            7:       return v / 210;
            8:       return v / 272;
            9:       return v / 342;
            10:      return v / 420;
            default: return v;
        endcase
    endfunction

    // Full-wave Q1.15 sine entry i of a table with 2^bits entries.
    // Evaluated at elaboration only.
    function automatic t_sine sine_entry(int unsigned bits, int unsigned i);
        int unsigned       qb;
        int unsigned       quarter;
        int unsigned       r;
        int unsigned       k;
        logic [1:0]        q;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint            sum;
        t_sine             v;
        qb      = bits - 2;
        quarter = 32'd1 << qb;
        q       = 2'((i >> qb) & 3);
        r       = i & (quarter - 1);
        k       = q[0] ? (quarter - r) : r;
        x       = (64'(k) * HALF_PI_Q30) >> qb;
        x2      = (x * x) >> 30;
        t       = x;
        sum     = longint'(x);
        for (int unsigned n = 1; n <= 10; n++) begin
            t = term_div(n, (t * x2) >> 30);
            if (n[0]) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum <= 0) begin
            v = '0;
        end else begin
            sum = (sum + 64'sd16384) >>> 15;
            if (sum > 64'sd32767) begin
                sum = 64'sd32767;
            end
            v = t_sine'(sum);
        end
        return q[1] ? -v : v;
    endfunction

endpackage

// ===== hdl/rmod_in_if.sv =====
// Input frame channel: four Q1.23 samples with valid/ready.
interface rmod_in_if;
    logic              valid;
    logic              ready;
    rmod_pkg::t_sample sample_ch0;
    rmod_pkg::t_sample sample_ch1;
    rmod_pkg::t_sample sample_ch2;
    rmod_pkg::t_sample sample_ch3;

    modport source (output valid, output sample_ch0, output sample_ch1,
                    output sample_ch2, output sample_ch3, input ready);
    modport sink   (input valid, input sample_ch0, input sample_ch1,
                    input sample_ch2, input sample_ch3, output ready);
endinterface

// ===== hdl/rmod_out_if.sv =====
// Output frame channel: four modulated Q1.23 samples with valid/ready.
interface rmod_out_if;
    logic              valid;
    logic              ready;
    rmod_pkg::t_sample mod_ch0;
    rmod_pkg::t_sample mod_ch1;
    rmod_pkg::t_sample mod_ch2;
    rmod_pkg::t_sample mod_ch3;

    modport source (output valid, output mod_ch0, output mod_ch1,
                    output mod_ch2, output mod_ch3, input ready);
    modport sink   (input valid, input mod_ch0, input mod_ch1,
                    input mod_ch2, input mod_ch3, output ready);
endinterface

// ===== hdl/rmod_cfg_if.sv =====
// Configuration write channel: register index and data with valid/ready.
interface rmod_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rmod_pkg::CFG_IDX_W-1:0]    index;
    logic [rmod_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rmod_nco.sv =====
// Phase accumulator and sine table with registered read.
module rmod_nco #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_acc,
    input  logic                             i_load,
    input  logic [rmod_pkg::PHASE_W-1:0]     i_phase_inc,
    output rmod_pkg::t_sine                  o_sine
);
    localparam int unsigned TABLE_SIZE = 1 << SINE_TABLE_BITS;

    logic [rmod_pkg::PHASE_W-1:0] r_phase;
    logic [SINE_TABLE_BITS-1:0]   w_idx;
    rmod_pkg::t_sine              w_rom [TABLE_SIZE];
    rmod_pkg::t_sine              r_sine;

    // Constant sine table, built at elaboration
    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
        assign w_rom[g] = rmod_pkg::sine_entry(SINE_TABLE_BITS, g);
    end

    assign w_idx = r_phase[rmod_pkg::PHASE_W-1 -: SINE_TABLE_BITS];

    // Phase advances once per accepted frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_acc) begin
            r_phase <= r_phase + i_phase_inc;
        end
    end

    // Table read, registered alongside the frame
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sine <= w_rom[w_idx];
        end
    end

    assign o_sine = r_sine;

endmodule

// ===== hdl/rmod_lane.sv =====
// One modulation lane: sample times carrier, round half up, saturate; unmodulated lanes pass the sample through.
module rmod_lane (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_mod,
    input  rmod_pkg::t_sample i_sample,
    input  rmod_pkg::t_sine   i_sine,
    output rmod_pkg::t_sample o_result
);
    localparam int unsigned PROD_W = rmod_pkg::SAMPLE_W + rmod_pkg::SINE_W;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    rmod_pkg::t_sample        r_pass;
    logic                     r_mod;
    logic signed [PROD_W:0]   w_sum;
    logic signed [PROD_W:0]   w_shr;
    rmod_pkg::t_sample        w_sat;

    assign w_prod = PROD_W'(i_sample) * PROD_W'(i_sine);

    // Product register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= w_prod;
            r_pass <= i_sample;
            r_mod  <= i_mod;
        end
    end

    // Round to Q1.23 and clamp
    assign w_sum = (PROD_W+1)'(r_prod) + 41'sd16384;
    assign w_shr = w_sum >>> 15;

    always_comb begin
        if (w_shr > 41'sd8388607) begin
            w_sat = 24'sh7FFFFF;
        end else if (w_shr < -41'sd8388608) begin
            w_sat = 24'sh800000;
        end else begin
            w_sat = w_shr[rmod_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_result = r_mod ? w_sat : r_pass;

endmodule

// ===== hdl/ring_modulator.sv =====
// Ring modulator top level: NCO, parallel multiplier lanes, output merge register.
// Each frame of four Q1.23 samples is multiplied lane by lane by one shared sine
// carrier value; lanes below min(active_channels, LANES) are modulated, the others
// pass their sample through. The block takes one frame per clock cycle while the
// output is not stalled. A frame passes through the registered sine table read,
// then the per-lane multiplier, then rounding and saturation into the
// output register. Backpressure on the output stalls the pipeline stage by stage,
// so bubbles are squeezed out before the input is held off. The carrier phase
// advances by phase_increment after every accepted frame; the first frame after
// reset uses phase zero.
module ring_modulator #(
    parameter int unsigned LANES           = 4,
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmod_in_if.sink     i_frame,
    rmod_out_if.source  o_mod,
    rmod_cfg_if.sink    i_cfg
);
    localparam int unsigned NF      = rmod_pkg::NUM_FIELDS;
    localparam int unsigned NUM_MOD = (LANES < NF) ? LANES : NF;

    logic [rmod_pkg::PHASE_W-1:0]  r_phase_inc;
    logic [rmod_pkg::ACTIVE_W-1:0] r_active;

    logic w_en1;
    logic w_en2;
    logic w_en3;
    logic w_acc;
    logic r_v1;
    logic r_v2;
    logic r_v3;

    rmod_pkg::t_sample w_in   [NF];
    rmod_pkg::t_sample r_smp1 [NF];
    logic [NF-1:0]     r_mod1;
    rmod_pkg::t_sample w_res  [NF];
    rmod_pkg::t_sample r_out  [NF];
    rmod_pkg::t_sine   w_sine;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_active    <= rmod_pkg::ACTIVE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rmod_pkg::REG_PHASE_INC: r_phase_inc <= i_cfg.data;
                rmod_pkg::REG_ACTIVE:    r_active    <= i_cfg.data[rmod_pkg::ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when the next one moves
    assign w_en3 = !r_v3 || o_mod.ready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_frame.ready = w_en1;
    assign w_acc = i_frame.valid && w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_frame.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign w_in[0] = i_frame.sample_ch0;
    assign w_in[1] = i_frame.sample_ch1;
    assign w_in[2] = i_frame.sample_ch2;
    assign w_in[3] = i_frame.sample_ch3;

    // Carrier
    rmod_nco #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_nco (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_load      (w_en1),
        .i_phase_inc (r_phase_inc),
        .o_sine      (w_sine)
    );

    // Lanes: multiplier copies for the lanes that exist, delay for the rest
    for (genvar j = 0; j < NF; j++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (w_en1) begin
                r_smp1[j] <= w_in[j];
                r_mod1[j] <= (3'(j) < r_active);
            end
        end

        if (j < NUM_MOD) begin : g_mul
            rmod_lane u_lane (
                .i_clk    (i_clk),
                .i_load   (w_en2),
                .i_mod    (r_mod1[j]),
                .i_sample (r_smp1[j]),
                .i_sine   (w_sine),
                .o_result (w_res[j])
            );
        end else begin : g_pass
            rmod_pkg::t_sample r_dly;
            always_ff @(posedge i_clk) begin
                if (w_en2) begin
                    r_dly <= r_smp1[j];
                end
            end
            assign w_res[j] = r_dly;
        end

        // Merge lane results into the output frame register
        always_ff @(posedge i_clk) begin
            if (w_en3) begin
                r_out[j] <= w_res[j];
            end
        end
    end

    assign o_mod.valid   = r_v3;
    assign o_mod.mod_ch0 = r_out[0];
    assign o_mod.mod_ch1 = r_out[1];
    assign o_mod.mod_ch2 = r_out[2];
    assign o_mod.mod_ch3 = r_out[3];

    // A full, stalled pipeline holds off the input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !o_mod.ready) |-> !i_frame.ready)
        else $error("input accepted while pipeline full and stalled");

    // Phase moves only on an accepted frame
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> (u_nco.r_phase == $past(u_nco.r_phase)))
        else $error("carrier phase changed without a frame");

    // A new output frame comes only from a valid multiplier stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v3) |-> $past(r_v2))
        else $error("output valid without a frame in the multiply stage");

endmodule
